FILE: hw/rtl/sfr_pkg.sv
// Shared types and constants of the stream find-and-replace block.
package sfr_pkg;

  // Widest pattern or replacement that the register map can carry.
  localparam int MAX_BYTES       = 8;
  localparam int COUNT_W         = 4;
  localparam int PAT_MAX_DEF     = 8;
  localparam int REP_MAX_DEF     = 8;
  localparam int QUEUE_DEPTH_DEF = 4;
  localparam int CFG_INDEX_W     = 2;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_PATTERN_LEN   = 2'd0,
    REG_PATTERN_BYTES = 2'd1,
    REG_REPLACE_LEN   = 2'd2,
    REG_REPLACE_BYTES = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [COUNT_W-1:0]     pattern_len;
    logic [8*MAX_BYTES-1:0] pattern_bytes;
    logic [COUNT_W-1:0]     replace_len;
    logic [8*MAX_BYTES-1:0] replace_bytes;
  } cfg_t;

  // One emit command: the first count bytes of data, then end of stream if last.
  typedef struct packed {
    logic [8*MAX_BYTES-1:0] data;
    logic [COUNT_W-1:0]     count;
    logic                   last;
  } cmd_t;

endpackage

FILE: hw/rtl/sfr_front.sv
// Front end: holds possible match bytes, classifies each input byte into an emit command.
module sfr_front #(
  parameter int PAT_MAX = sfr_pkg::PAT_MAX_DEF,
  parameter int REP_MAX = sfr_pkg::REP_MAX_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          accept,
  input  logic [7:0]    in_byte,
  input  logic          in_last,
  input  sfr_pkg::cfg_t cfg,
  output logic          cmd_push,
  output sfr_pkg::cmd_t cmd
);

  localparam int CW = $clog2(PAT_MAX + 1);

  logic [7:0]    held [PAT_MAX];
  logic [CW-1:0] held_count;

  logic [7:0]    win [PAT_MAX];
  logic [7:0]    held_next [PAT_MAX];
  logic [CW-1:0] held_count_next;
  logic [CW-1:0] wlen;
  logic [CW-1:0] plen;
  logic [sfr_pkg::COUNT_W-1:0] rlen;
  logic          full_eq;
  logic          match;
  logic [PAT_MAX:0] ok;
  logic [CW-1:0] shift;

  always_comb begin
    if (cfg.pattern_len == '0) begin
      plen = CW'(1);
    end else if (cfg.pattern_len > sfr_pkg::COUNT_W'(PAT_MAX)) begin
      plen = CW'(PAT_MAX);
    end else begin
      plen = CW'(cfg.pattern_len);
    end
    if (cfg.replace_len > sfr_pkg::COUNT_W'(REP_MAX)) begin
      rlen = sfr_pkg::COUNT_W'(REP_MAX);
    end else begin
      rlen = cfg.replace_len;
    end
  end

  // The window is the held bytes with the new byte appended.
  always_comb begin
    wlen = held_count + CW'(1);
    for (int i = 0; i < PAT_MAX; i++) begin
      win[i] = (CW'(i) < held_count) ? held[i] : in_byte;
    end
  end

  // ok[s] is set when dropping s bytes from the front leaves a proper pattern prefix.
  always_comb begin
    full_eq = 1'b1;
    for (int i = 0; i < PAT_MAX; i++) begin
      if (CW'(i) < wlen && win[i] != cfg.pattern_bytes[8*i +: 8]) begin
        full_eq = 1'b0;
      end
    end
    match = (wlen == plen) && full_eq;

    for (int s = 0; s <= PAT_MAX; s++) begin
      ok[s] = (CW'(s) <= wlen) && ((wlen - CW'(s)) < plen);
      for (int i = s; i < PAT_MAX; i++) begin
        if (CW'(i) < wlen && win[i] != cfg.pattern_bytes[8*(i-s) +: 8]) begin
          ok[s] = 1'b0;
        end
      end
    end

    shift = wlen;
    for (int s = PAT_MAX; s >= 0; s--) begin
      if (ok[s]) begin
        shift = CW'(s);
      end
    end
  end

  always_comb begin
    for (int j = 0; j < PAT_MAX; j++) begin
      held_next[j] = win[j];
      for (int s = 1; s < PAT_MAX - j; s++) begin
        if (shift == CW'(s)) begin
          held_next[j] = win[j + s];
        end
      end
    end
    held_count_next = (match || in_last) ? '0 : (wlen - shift);

    cmd.last = in_last;
    cmd.data = '0;
    if (match) begin
      cmd.data  = cfg.replace_bytes;
      cmd.count = rlen;
    end else begin
      for (int i = 0; i < PAT_MAX; i++) begin
        cmd.data[8*i +: 8] = win[i];
      end
      cmd.count = in_last ? sfr_pkg::COUNT_W'(wlen) : sfr_pkg::COUNT_W'(shift);
    end
    cmd_push = accept && (cmd.count != '0 || in_last);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_count <= '0;
    end else if (accept) begin
      held_count <= held_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      held <= held_next;
    end
  end

endmodule

FILE: hw/rtl/sfr_queue.sv
// Command queue between the front end and the output sequencer.
module sfr_queue #(
  parameter int DEPTH = sfr_pkg::QUEUE_DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  sfr_pkg::cmd_t push_cmd,
  input  logic          pop,
  output sfr_pkg::cmd_t head,
  output logic          full,
  output logic          empty
);

  localparam int PW = $clog2(DEPTH);
  localparam int NW = $clog2(DEPTH + 1);

  sfr_pkg::cmd_t mem [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [NW-1:0] fill;

  assign head  = mem[rd_ptr];
  assign full  = (fill == NW'(DEPTH));
  assign empty = (fill == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        fill <= fill + NW'(1);
      end else if (pop && !push) begin
        fill <= fill - NW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_cmd;
    end
  end

endmodule

FILE: hw/rtl/sfr_back.sv
// Back end: walks each queued command out one byte per cycle, while out_stall is low, into the output register.
module sfr_back (
  input  logic          clk,
  input  logic          rst,
  input  sfr_pkg::cmd_t head,
  input  logic          q_empty,
  output logic          pop,
  input  logic          out_stall,
  output logic          out_valid,
  output logic [7:0]    out_byte,
  output logic          out_empty,
  output logic          out_last
);

  localparam int IW = $clog2(sfr_pkg::MAX_BYTES);

  logic [IW-1:0] idx;
  logic          load;
  logic          final_item;

  always_comb begin
    load       = !out_valid || !out_stall;
    final_item = (head.count == '0) ||
                 ({{(sfr_pkg::COUNT_W-IW){1'b0}}, idx} == head.count - sfr_pkg::COUNT_W'(1));
    pop        = load && !q_empty && final_item;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= '0;
    end else if (load) begin
      out_valid <= !q_empty;
      if (!q_empty) begin
        idx <= final_item ? '0 : idx + IW'(1);
      end
    end
  end

  // A command with no bytes only ends the stream and yields a single empty request.
  always_ff @(posedge clk) begin
    if (load && !q_empty) begin
      out_byte  <= (head.count == '0) ? 8'd0 : head.data[8*idx +: 8];
      out_empty <= (head.count == '0);
      out_last  <= head.last && final_item;
    end
  end

endmodule

FILE: hw/rtl/stream_find_replace.sv
// Stream find-and-replace: top level with configuration registers and checks.
//
// The block accepts one text byte per cycle while in_stall is low and replaces
// every leftmost, non-overlapping occurrence of the pattern (1 to PAT_MAX
// bytes) with the replacement (0 to REP_MAX bytes); bytes that may still start
// a match are held back until they are resolved. The front end classifies each
// byte in the cycle it is accepted and queues one command holding the bytes it
// releases, if any; the back end sends these out one byte per cycle through an
// output register, so a plain byte passes the queue memory and then the output
// register, and while out_stall is low the output port sets the sustained rate
// at one result byte per cycle. A match, a mismatch after held bytes or the
// final byte can release up to eight bytes at once; the QUEUE_DEPTH-entry
// command queue absorbs such bursts, and in_stall rises only while it is full.
// A final byte with nothing to release gives one request with out_empty set.
// Write configuration only while the block is idle; cfg_ready is always high.
module stream_find_replace #(
  parameter int PAT_MAX     = sfr_pkg::PAT_MAX_DEF,
  parameter int REP_MAX     = sfr_pkg::REP_MAX_DEF,
  parameter int QUEUE_DEPTH = sfr_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [7:0]                        in_byte,
  input  logic                              in_last,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [7:0]                        out_byte,
  output logic                              out_empty,
  output logic                              out_last,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [sfr_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [8*sfr_pkg::MAX_BYTES-1:0]   cfg_data
);

  sfr_pkg::cfg_t cfg;
  sfr_pkg::cmd_t push_cmd;
  sfr_pkg::cmd_t head;
  logic          accept;
  logic          cmd_push;
  logic          cmd_pop;
  logic          q_full;
  logic          q_empty;

  assign cfg_ready = 1'b1;
  assign in_stall  = q_full;
  assign accept    = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pattern_len   <= sfr_pkg::COUNT_W'(1);
      cfg.pattern_bytes <= '0;
      cfg.replace_len   <= '0;
      cfg.replace_bytes <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (sfr_pkg::cfg_reg_t'(cfg_index))
        sfr_pkg::REG_PATTERN_LEN:   cfg.pattern_len   <= cfg_data[sfr_pkg::COUNT_W-1:0];
        sfr_pkg::REG_PATTERN_BYTES: cfg.pattern_bytes <= cfg_data;
        sfr_pkg::REG_REPLACE_LEN:   cfg.replace_len   <= cfg_data[sfr_pkg::COUNT_W-1:0];
        sfr_pkg::REG_REPLACE_BYTES: cfg.replace_bytes <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  sfr_front #(
    .PAT_MAX (PAT_MAX),
    .REP_MAX (REP_MAX)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .in_byte  (in_byte),
    .in_last  (in_last),
    .cfg      (cfg),
    .cmd_push (cmd_push),
    .cmd      (push_cmd)
  );

  sfr_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (cmd_push),
    .push_cmd (push_cmd),
    .pop      (cmd_pop),
    .head     (head),
    .full     (q_full),
    .empty    (q_empty)
  );

  sfr_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .q_empty   (q_empty),
    .pop       (cmd_pop),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_byte  (out_byte),
    .out_empty (out_empty),
    .out_last  (out_last)
  );

  // The front end must never push into a full queue.
  assert property (@(posedge clk) disable iff (rst) cmd_push |-> !q_full)
    else $error("command pushed into a full queue");

  // A request that carries no byte always ends the stream and has a zero byte.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_empty) |-> (out_last && out_byte == 8'd0))
    else $error("empty request without end of stream");

  // Every accepted final byte produces a command, so the queue cannot be empty next cycle.
  assert property (@(posedge clk) disable iff (rst)
    (accept && in_last) |=> !q_empty)
    else $error("final byte produced no command");

endmodule
